/* rtl/upd_pkg.sv */
// Shared types, character codes and hex helpers for the URL percent decoder.
// No dependencies.
`default_nettype none

package upd_pkg;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_PCT   = 2'd1;
    localparam logic [1:0] PEND_DIGIT = 2'd2;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] top;
        logic       last;
    } entry_t;

    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        r = (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF)
            || (c >= CH_UA && c <= CH_UF);
        return r;
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= CH_0 && c <= CH_9)
        begin
            v = c - CH_0;
        end
        else if (c >= CH_LA && c <= CH_LF)
        begin
            v = c - CH_LA + 8'd10;
        end
        else if (c >= CH_UA && c <= CH_UF)
        begin
            v = c - CH_UA + 8'd10;
        end
        return v[3:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/url_percent_decoder.sv */
// Top level of the streaming URL percent decoder.
// Depends on upd_pkg, upd_front, upd_queue and upd_back.
//
// Usage:
//   Input channel (in_valid/in_ready, in_byte, in_last) takes one encoded
//   byte per item; in_last marks the final byte of a string. Output channel
//   (out_valid/out_ready, out_byte, out_last, decoded_count) gives decoded
//   bytes in order; out_last marks the final decoded byte of a string and
//   decoded_count is the saturating length of the string so far.
//   '%' plus two hex digits decodes to one byte, '+' becomes a space, a
//   broken or truncated escape passes through literally.
// Path: a byte that releases output passes the queue memory, then the output
//   register on out_*; a '%' or first hex digit is held until the next byte.
// Throughput: one input item per cycle while the queue is not full and each
//   item releases at most one byte. The back end emits one byte per cycle
//   while out_ready allows; the two or three bytes of a flushed broken escape
//   are absorbed by the four-entry queue between front and back end.
// Stall: when out_ready is low the output register holds, the queue fills,
//   and in_ready drops only once the queue is full.
// Reset: rst_n clears held escape state, queue and length count; no
//   clearing pass, the block takes items as soon as reset is released.
`default_nettype none

module url_percent_decoder #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             in_byte,
    input  wire logic                   in_last,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [7:0]                  out_byte,
    output logic                        out_last,
    output logic [COUNT_WIDTH-1:0]      decoded_count
);
    import upd_pkg::*;

    entry_t q_in;
    entry_t q_head;
    logic   q_push;
    logic   q_pop;
    logic   q_empty;
    logic   q_full;

    upd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    upd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    upd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .empty         (q_empty),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .out_last      (out_last),
        .decoded_count (decoded_count)
    );

endmodule

`default_nettype wire

/* rtl/upd_front.sv */
// Front end: accepts raw bytes, tracks a held '%' and digit, and builds one
// queue entry of up to three decoded bytes per item. Uses upd_pkg.
`default_nettype none

module upd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      in_byte,
    input  wire logic            in_last,
    input  wire logic            q_full,
    output logic                 q_push,
    output upd_pkg::entry_t      q_data
);
    import upd_pkg::*;

    logic [1:0] pend_cnt_reg;
    logic [1:0] pend_cnt_next;
    logic [7:0] pend_digit_reg;
    logic [1:0] n_out;
    logic       f_hold;
    logic [7:0] f_byte;
    logic       accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign f_hold   = (in_byte == CH_PCT) && !in_last;
    assign f_byte   = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;

    always_comb
    begin
        pend_cnt_next = PEND_NONE;
        n_out         = 2'd0;
        q_data.byte0  = f_byte;
        q_data.byte1  = f_byte;
        q_data.byte2  = f_byte;
        case (pend_cnt_reg)
            PEND_PCT:
            begin
                if (is_hex(in_byte) && !in_last)
                begin
                    pend_cnt_next = PEND_DIGIT;
                end
                else
                begin
                    q_data.byte0 = CH_PCT;
                    if (f_hold)
                    begin
                        pend_cnt_next = PEND_PCT;
                        n_out         = 2'd1;
                    end
                    else
                    begin
                        n_out = 2'd2;
                    end
                end
            end
            PEND_DIGIT:
            begin
                if (is_hex(in_byte) && is_hex(pend_digit_reg))
                begin
                    q_data.byte0 = {hex_val(pend_digit_reg), hex_val(in_byte)};
                    n_out        = 2'd1;
                end
                else
                begin
                    q_data.byte0 = CH_PCT;
                    q_data.byte1 = pend_digit_reg;
                    if (f_hold)
                    begin
                        pend_cnt_next = PEND_PCT;
                        n_out         = 2'd2;
                    end
                    else
                    begin
                        n_out = 2'd3;
                    end
                end
            end
            default:
            begin
                if (f_hold)
                begin
                    pend_cnt_next = PEND_PCT;
                end
                else
                begin
                    n_out = 2'd1;
                end
            end
        endcase
        q_data.top  = n_out - 2'd1;
        q_data.last = in_last;
    end

    assign q_push = accept && (n_out != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg <= PEND_NONE;
        end
        else if (accept)
        begin
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && pend_cnt_next == PEND_DIGIT)
        begin
            pend_digit_reg <= in_byte;
        end
    end

endmodule

`default_nettype wire

/* rtl/upd_queue.sv */
// Short entry queue between front and back ends.
// Uses upd_pkg for the entry type and depth.
`default_nettype none

module upd_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire upd_pkg::entry_t push_data,
    input  wire logic            pop,
    output upd_pkg::entry_t      head,
    output logic                 empty,
    output logic                 full
);
    import upd_pkg::*;

    entry_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic [QCNT_W-1:0]   cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/upd_back.sv */
// Back end: drains queue entries one byte per cycle, while out_ready allows,
// into an output register and keeps the saturating decoded length. Uses upd_pkg.
`default_nettype none

module upd_back #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire upd_pkg::entry_t        head,
    input  wire logic                   empty,
    output logic                        pop,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [7:0]                  out_byte,
    output logic                        out_last,
    output logic [COUNT_WIDTH-1:0]      decoded_count
);
    import upd_pkg::*;

    logic [1:0]             idx_reg;
    logic [COUNT_WIDTH-1:0] len_reg;
    logic [COUNT_WIDTH-1:0] len_next;
    logic                   out_valid_reg;
    logic [7:0]             out_byte_reg;
    logic                   out_last_reg;
    logic [COUNT_WIDTH-1:0] out_count_reg;
    logic                   load;
    logic                   idx_end;
    logic [7:0]             sel_byte;

    assign load     = !empty && (!out_valid_reg || out_ready);
    assign idx_end  = (idx_reg == head.top);
    assign pop      = load && idx_end;
    assign len_next = (len_reg == {COUNT_WIDTH{1'b1}}) ? len_reg : len_reg + 1'b1;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = head.byte0;
            2'd1:    sel_byte = head.byte1;
            default: sel_byte = head.byte2;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= idx_end ? 2'd0 : idx_reg + 2'd1;
                len_reg       <= (idx_end && head.last) ? '0 : len_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg  <= sel_byte;
            out_last_reg  <= idx_end && head.last;
            out_count_reg <= len_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign out_last      = out_last_reg;
    assign decoded_count = out_count_reg;

endmodule

`default_nettype wire

/* test/upd_checker.sv */
`timescale 1ns / 1ps
// Result checker for url_percent_decoder: watches the input and output item
// channels, predicts every decoded byte and compares them in order. Uses upd_pkg.
module upd_checker #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_ready,
    input  wire logic [7:0]             in_byte,
    input  wire logic                   in_last,
    input  wire logic                   out_valid,
    input  wire logic                   out_ready,
    input  wire logic [7:0]             out_byte,
    input  wire logic                   out_last,
    input  wire logic [COUNT_WIDTH-1:0] decoded_count,
    output int                          mismatches,
    output int                          awaiting,
    output int                          checked
);
    import upd_pkg::*;

    typedef struct packed {
        logic [7:0]             value;
        logic                   last;
        logic [COUNT_WIDTH-1:0] count;
    } decoded_t;

    decoded_t               awaited_bytes[$];
    logic [1:0]             held_kind = PEND_NONE;
    logic [7:0]             held_digit = 8'd0;
    logic [COUNT_WIDTH-1:0] run_length = '0;
    int                     step_results = 0;

    initial
    begin
        mismatches = 0;
        awaiting = 0;
        checked = 0;
    end

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= 30)
        begin
            $display("mismatch at %0t ns: %s", $realtime, msg);
        end
    endtask

    function automatic int digit_value(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
        begin
            return int'(c - CH_0);
        end
        if (c >= CH_LA && c <= CH_LF)
        begin
            return int'(c - CH_LA) + 10;
        end
        if (c >= CH_UA && c <= CH_UF)
        begin
            return int'(c - CH_UA) + 10;
        end
        return 16;
    endfunction

    task automatic push_byte(input logic [7:0] v);
        decoded_t e;
        if (run_length != '1)
        begin
            run_length = run_length + 1'b1;
        end
        e.value = v;
        e.last = 1'b0;
        e.count = run_length;
        awaited_bytes.push_back(e);
        step_results++;
    endtask

    task automatic take_fresh(input logic [7:0] b, input logic last);
        if (b == CH_PCT && !last)
        begin
            held_kind = PEND_PCT;
        end
        else if (b == CH_PLUS)
        begin
            push_byte(CH_SPACE);
        end
        else
        begin
            push_byte(b);
        end
    endtask

    task automatic decode_input(input logic [7:0] b, input logic last);
        logic [1:0] was_held;
        decoded_t   tail;
        int         hi;
        int         lo;
        was_held = held_kind;
        held_kind = PEND_NONE;
        step_results = 0;
        if (was_held == PEND_PCT)
        begin
            if (digit_value(b) < 16 && !last)
            begin
                held_kind = PEND_DIGIT;
                held_digit = b;
            end
            else
            begin
                push_byte(CH_PCT);
                take_fresh(b, last);
            end
        end
        else if (was_held == PEND_DIGIT)
        begin
            hi = digit_value(held_digit);
            lo = digit_value(b);
            if (hi < 16 && lo < 16)
            begin
                push_byte(8'((hi << 4) | lo));
            end
            else
            begin
                push_byte(CH_PCT);
                push_byte(held_digit);
                take_fresh(b, last);
            end
        end
        else
        begin
            take_fresh(b, last);
        end
        if (last)
        begin
            if (step_results > 0)
            begin
                tail = awaited_bytes.pop_back();
                tail.last = 1'b1;
                awaited_bytes.push_back(tail);
            end
            held_kind = PEND_NONE;
            run_length = '0;
        end
    endtask

    task automatic check_result();
        decoded_t e;
        if (awaited_bytes.size() == 0)
        begin
            report($sformatf("output byte %02h with none awaited", out_byte));
        end
        else
        begin
            e = awaited_bytes.pop_front();
            checked++;
            if (out_byte !== e.value)
            begin
                report($sformatf("out_byte %02h, expected %02h", out_byte, e.value));
            end
            if (out_last !== e.last)
            begin
                report($sformatf("out_last %b, expected %b", out_last, e.last));
            end
            if (decoded_count !== e.count)
            begin
                report($sformatf("decoded_count %0d, expected %0d", decoded_count, e.count));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                check_result();
            end
            if (in_valid && in_ready)
            begin
                decode_input(in_byte, in_last);
            end
            awaiting <= awaited_bytes.size();
        end
    end

endmodule

/* test/tb_url_percent_decoder.sv */
`timescale 1ns / 1ps
// Testbench top for url_percent_decoder: clock, reset, encoded-string stimulus,
// output stalls and the verdict. Uses upd_pkg, the decoder RTL and upd_checker.
module tb_url_percent_decoder;
    import upd_pkg::*;

    localparam int ITEM_TARGET = 470;
    localparam int QUIET_TAIL  = 60;
    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        in_last;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [15:0] decoded_count;

    int mismatches;
    int awaiting;
    int checked;
    int items_sent = 0;
    int strings_sent = 0;
    int outputs_seen = 0;
    int idle_cycles = 0;
    bit quiet_tail = 1'b0;
    bit hold_done = 1'b0;

    url_percent_decoder #(
        .COUNT_WIDTH(16)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_byte(in_byte),
        .in_last(in_last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_byte(out_byte),
        .out_last(out_last),
        .decoded_count(decoded_count)
    );

    upd_checker #(
        .COUNT_WIDTH(16)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_byte(in_byte),
        .in_last(in_last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_byte(out_byte),
        .out_last(out_last),
        .decoded_count(decoded_count),
        .mismatches(mismatches),
        .awaiting(awaiting),
        .checked(checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_item(input logic [7:0] b, input logic last);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        in_last <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        if (last)
        begin
            strings_sent++;
        end
    endtask

    task automatic send_text(input string s, input bit ends);
        for (int i = 0; i < s.len(); i++)
        begin
            send_item(s[i], ends && (i == s.len() - 1));
        end
    endtask

    function automatic logic [7:0] pick_hex();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] pick_near_hex();
        string near;
        near = "/:@G`g";
        return near[$urandom_range(0, 5)];
    endfunction

    task automatic send_random_string();
        logic [7:0] text[$];
        int         span;
        span = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
        while (text.size() < span)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    text.push_back(CH_PCT);
                    text.push_back(pick_hex());
                    text.push_back(pick_hex());
                end
                4:
                begin
                    text.push_back(CH_PCT);
                    text.push_back(pick_hex());
                    text.push_back(pick_near_hex());
                end
                5:
                begin
                    text.push_back(CH_PCT);
                    text.push_back(pick_near_hex());
                end
                6: text.push_back(CH_PLUS);
                7: text.push_back(8'($urandom_range(0, 255)));
                8: text.push_back(pick_hex());
                default: text.push_back(CH_PCT);
            endcase
        end
        foreach (text[i])
        begin
            send_item(text[i], i == text.size() - 1);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_byte <= 8'd0;
        in_last <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_text("%4a", 1'b1);
        send_text("%fF+", 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        send_text("%G%%41%", 1'b1);
        send_text("%4z", 1'b1);
        send_text("%9", 1'b1);
        send_text("%2%", 1'b1);
        send_text("A", 1'b1);

        while (items_sent < ITEM_TARGET)
        begin
            if (ITEM_TARGET - items_sent <= QUIET_TAIL)
            begin
                quiet_tail = 1'b1;
            end
            send_random_string();
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (awaiting != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d encoded strings in %0d items; %0d decoded bytes compared.",
                 strings_sent, items_sent, checked);
        $display("Mixed-case escapes, plus signs, broken and cut-off escapes, and a long"
                 , " output hold-off were exercised.");
        if (mismatches == 0 && awaiting == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        out_ready <= 1'b0;
        repeat (6) @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                outputs_seen++;
            end
            if (outputs_seen >= 40 && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule

/* sim.f */
rtl/upd_pkg.sv
rtl/upd_front.sv
rtl/upd_queue.sv
rtl/upd_back.sv
rtl/url_percent_decoder.sv
test/upd_checker.sv
test/tb_url_percent_decoder.sv
